>>> sv/blsu_pkg.sv
// Shared constants and the command type of the Bresenham line stepper.
package blsu_pkg;

    // Coordinate width of the endpoint and pixel fields.
    localparam int COORD_BITS = 12;
    // Signed endpoint differences need one bit more than a coordinate.
    localparam int DELTA_BITS = COORD_BITS + 1;
    // The error term swings between minus and plus twice the largest delta.
    localparam int ERR_BITS = COORD_BITS + 3;

    // Queue between the front and the back; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Action codes of an input item.
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_ADVANCE = 1'b1;

    // A classified item as it travels from the front to the back.
    typedef struct packed {
        logic                         is_start;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] goal_x;
        logic signed [COORD_BITS-1:0] goal_y;
        logic                         x_neg;
        logic                         y_neg;
        logic                         x_major;
        logic signed [ERR_BITS-1:0]   err_init;
        logic signed [ERR_BITS-1:0]   err_minor;
        logic signed [ERR_BITS-1:0]   err_both;
        logic [31:0]                  color;
    } cmd_t;

endpackage

>>> sv/blsu_front.sv
// Front part: classifies an input item and works out the line setup of a start item.
module blsu_front
(
    input  logic                                 cmd_valid,
    input  logic                                 action,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] end_y,
    input  logic [31:0]                          line_color,
    input  logic                                 queue_full,
    output logic                                 cmd_stall,
    output logic                                 push,
    output blsu_pkg::cmd_t                       cmd
);

    logic signed [blsu_pkg::DELTA_BITS-1:0] dx;
    logic signed [blsu_pkg::DELTA_BITS-1:0] dy;
    logic [blsu_pkg::DELTA_BITS-1:0]        abs_dx;
    logic [blsu_pkg::DELTA_BITS-1:0]        abs_dy;
    logic [blsu_pkg::DELTA_BITS-1:0]        twice_dx;
    logic [blsu_pkg::DELTA_BITS-1:0]        twice_dy;
    logic                                   x_major;
    logic [blsu_pkg::DELTA_BITS-1:0]        twice_minor;
    logic [blsu_pkg::DELTA_BITS-1:0]        twice_major;
    logic [blsu_pkg::DELTA_BITS-1:0]        abs_major;

    assign dx = blsu_pkg::DELTA_BITS'(end_x) - blsu_pkg::DELTA_BITS'(start_x);
    assign dy = blsu_pkg::DELTA_BITS'(end_y) - blsu_pkg::DELTA_BITS'(start_y);

    assign abs_dx = dx[blsu_pkg::DELTA_BITS-1] ? -dx : dx;
    assign abs_dy = dy[blsu_pkg::DELTA_BITS-1] ? -dy : dy;

    // The absolute difference fits in a coordinate width, so doubling cannot overflow.
    assign twice_dx = {abs_dx[blsu_pkg::DELTA_BITS-2:0], 1'b0};
    assign twice_dy = {abs_dy[blsu_pkg::DELTA_BITS-2:0], 1'b0};

    assign x_major = twice_dx > twice_dy;
    assign twice_minor = x_major ? twice_dy : twice_dx;
    assign twice_major = x_major ? twice_dx : twice_dy;
    assign abs_major = x_major ? abs_dx : abs_dy;

    assign cmd_stall = queue_full;
    assign push = cmd_valid && !queue_full;

    always_comb
    begin
        cmd.is_start = (action == blsu_pkg::ACTION_START);
        cmd.start_x = start_x;
        cmd.start_y = start_y;
        cmd.goal_x = end_x;
        cmd.goal_y = end_y;
        cmd.x_neg = dx[blsu_pkg::DELTA_BITS-1];
        cmd.y_neg = dy[blsu_pkg::DELTA_BITS-1];
        cmd.x_major = x_major;
        cmd.err_init = $signed(blsu_pkg::ERR_BITS'(twice_minor))
                     - $signed(blsu_pkg::ERR_BITS'(abs_major));
        cmd.err_minor = $signed(blsu_pkg::ERR_BITS'(twice_minor));
        cmd.err_both = $signed(blsu_pkg::ERR_BITS'(twice_minor))
                     - $signed(blsu_pkg::ERR_BITS'(twice_major));
        cmd.color = line_color;
    end

endmodule

>>> sv/blsu_queue.sv
// Short queue of classified items between the front and the back.
module blsu_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  blsu_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output blsu_pkg::cmd_t head_cmd
);

    blsu_pkg::cmd_t                      mem_reg [blsu_pkg::QUEUE_DEPTH];
    logic [blsu_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [blsu_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [blsu_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [blsu_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [blsu_pkg::QUEUE_CNT_BITS-1:0] count_reg;
    logic [blsu_pkg::QUEUE_CNT_BITS-1:0] count_next;
    logic                                do_pop;

    assign full = (count_reg == blsu_pkg::QUEUE_CNT_BITS'(blsu_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= blsu_pkg::QUEUE_CNT_BITS'(blsu_pkg::QUEUE_DEPTH))
        else $error("queue holds more items than its depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on a lone write");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

>>> sv/blsu_back.sv
// Back part: holds the line state, steps the error term and drives the pixel register.
module blsu_back
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   head_valid,
    input  blsu_pkg::cmd_t                         head_cmd,
    output logic                                   pop,
    output logic                                   pix_valid,
    input  logic                                   pix_stall,
    output logic signed [blsu_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [blsu_pkg::COORD_BITS-1:0] pixel_y,
    output logic [31:0]                            pixel_color,
    output logic                                   last
);

    logic signed [blsu_pkg::COORD_BITS-1:0] cur_x_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] cur_x_next;
    logic signed [blsu_pkg::COORD_BITS-1:0] cur_y_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] cur_y_next;
    logic signed [blsu_pkg::COORD_BITS-1:0] goal_x_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] goal_x_next;
    logic signed [blsu_pkg::COORD_BITS-1:0] goal_y_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] goal_y_next;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_reg;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_next;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_minor_reg;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_minor_next;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_both_reg;
    logic signed [blsu_pkg::ERR_BITS-1:0]   err_both_next;
    logic                                   x_neg_reg;
    logic                                   x_neg_next;
    logic                                   y_neg_reg;
    logic                                   y_neg_next;
    logic                                   x_major_reg;
    logic                                   x_major_next;
    logic                                   active_reg;
    logic                                   active_next;
    logic [31:0]                            color_reg;
    logic [31:0]                            color_next;

    logic                                   pix_valid_reg;
    logic                                   pix_valid_next;
    logic signed [blsu_pkg::COORD_BITS-1:0] pixel_x_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] pixel_x_next;
    logic signed [blsu_pkg::COORD_BITS-1:0] pixel_y_reg;
    logic signed [blsu_pkg::COORD_BITS-1:0] pixel_y_next;
    logic [31:0]                            pixel_color_reg;
    logic [31:0]                            pixel_color_next;
    logic                                   last_reg;
    logic                                   last_next;

    logic                                   take;
    logic                                   emit;
    logic                                   fin;
    logic                                   minor_step;
    logic signed [blsu_pkg::COORD_BITS-1:0] step_x;
    logic signed [blsu_pkg::COORD_BITS-1:0] step_y;
    logic signed [blsu_pkg::COORD_BITS-1:0] adv_x;
    logic signed [blsu_pkg::COORD_BITS-1:0] adv_y;

    // The head item is taken whenever the pixel register is free or being emptied.
    assign take = head_valid && (!pix_valid_reg || !pix_stall);
    assign pop = take;

    assign minor_step = !err_reg[blsu_pkg::ERR_BITS-1];
    assign step_x = x_neg_reg ? '1 : blsu_pkg::COORD_BITS'(1);
    assign step_y = y_neg_reg ? '1 : blsu_pkg::COORD_BITS'(1);
    assign adv_x = (x_major_reg || minor_step) ? cur_x_reg + step_x : cur_x_reg;
    assign adv_y = (!x_major_reg || minor_step) ? cur_y_reg + step_y : cur_y_reg;

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        err_next = err_reg;
        err_minor_next = err_minor_reg;
        err_both_next = err_both_reg;
        x_neg_next = x_neg_reg;
        y_neg_next = y_neg_reg;
        x_major_next = x_major_reg;
        color_next = color_reg;
        emit = 1'b0;

        if (take && head_cmd.is_start)
        begin
            cur_x_next = head_cmd.start_x;
            cur_y_next = head_cmd.start_y;
            goal_x_next = head_cmd.goal_x;
            goal_y_next = head_cmd.goal_y;
            err_next = head_cmd.err_init;
            err_minor_next = head_cmd.err_minor;
            err_both_next = head_cmd.err_both;
            x_neg_next = head_cmd.x_neg;
            y_neg_next = head_cmd.y_neg;
            x_major_next = head_cmd.x_major;
            color_next = head_cmd.color;
            emit = 1'b1;
        end
        else if (take && active_reg)
        begin
            cur_x_next = adv_x;
            cur_y_next = adv_y;
            err_next = err_reg + (minor_step ? err_both_reg : err_minor_reg);
            emit = 1'b1;
        end

        fin = x_major_next ? (cur_x_next == goal_x_next) : (cur_y_next == goal_y_next);
        active_next = emit ? !fin : active_reg;

        pix_valid_next = emit || (pix_valid_reg && pix_stall);
        pixel_x_next = emit ? cur_x_next : pixel_x_reg;
        pixel_y_next = emit ? cur_y_next : pixel_y_reg;
        pixel_color_next = emit ? color_next : pixel_color_reg;
        last_next = emit ? fin : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            err_reg <= '0;
            err_minor_reg <= '0;
            err_both_reg <= '0;
            x_neg_reg <= 1'b0;
            y_neg_reg <= 1'b0;
            x_major_reg <= 1'b0;
            active_reg <= 1'b0;
            color_reg <= '0;
            pix_valid_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            err_reg <= err_next;
            err_minor_reg <= err_minor_next;
            err_both_reg <= err_both_next;
            x_neg_reg <= x_neg_next;
            y_neg_reg <= y_neg_next;
            x_major_reg <= x_major_next;
            active_reg <= active_next;
            color_reg <= color_next;
            pix_valid_reg <= pix_valid_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last = last_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid_reg && last_reg) |-> !active_reg)
        else $error("line still active while its final pixel waits");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(take) |-> ($stable(cur_x_reg) && $stable(cur_y_reg) && $stable(err_reg)))
        else $error("line state moved without a taken item");

    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !head_cmd.is_start && !active_reg && !(pix_valid_reg && pix_stall))
        |=> !pix_valid_reg)
        else $error("advance with no line produced a pixel");
`endif

endmodule

>>> sv/bresenham_line_stepper_unit.sv
// Top level of the Bresenham line stepper: front, item queue and stepping back end.
//
// This block rasterizes straight lines one pixel per item. A start item
// (action 0) loads both endpoints and a color and yields the first pixel;
// each advance item (action 1) yields the next pixel of the line, and the
// pixel whose major coordinate reaches the end point carries last. An
// advance item with no line in progress is taken and yields nothing, and a
// start item in the middle of a line drops the old line. The block sustains
// one item per clock while the output is not stalled: the pixel step is a
// single add on the registered error term in the back end, and that loop
// sets the rate. An accepted item is written into the two-entry item queue,
// and its pixel is then registered in the back end's output register. Items
// are taken while a pixel waits on a stalled output until the queue fills.
module bresenham_line_stepper_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    output logic                                   cmd_stall,
    input  logic                                   action,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] end_x,
    input  logic signed [blsu_pkg::COORD_BITS-1:0] end_y,
    input  logic [31:0]                            line_color,
    output logic                                   pix_valid,
    input  logic                                   pix_stall,
    output logic signed [blsu_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [blsu_pkg::COORD_BITS-1:0] pixel_y,
    output logic [31:0]                            pixel_color,
    output logic                                   last
);

    // Items flow front -> queue -> back; the queue lets each side stall on its own.
    logic           push;
    logic           queue_full;
    logic           head_valid;
    logic           pop;
    blsu_pkg::cmd_t front_cmd;
    blsu_pkg::cmd_t head_cmd;

    // The front classifies the item and, for a start, computes deltas, step
    // signs, major axis and the initial error term.
    blsu_front u_front
    (
        .cmd_valid  (cmd_valid),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .line_color (line_color),
        .queue_full (queue_full),
        .cmd_stall  (cmd_stall),
        .push       (push),
        .cmd        (front_cmd)
    );

    blsu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (front_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back end owns the line state and the output pixel register.
    blsu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last)
    );

endmodule
